/* hw/rtl/mpq_pkg.sv */
// shared types and constants for the multilevel priority queue
package mpq_pkg;

  localparam int CAPACITY   = 32;
  localparam int ID_BITS    = 8;
  localparam int MAX_LEVELS = 8;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int NL_W       = 4;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_UP     = 3'd1,
    CMD_DOWN   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_LEVEL = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               del;
    logic               app;
    logic               dump_clr;
    logic               dump_step;
    logic [ID_BITS-1:0] id;
    logic [LVL_W-1:0]   new_level;
    logic [LVL_W-1:0]   dump_lv;
  } cell_ctl_t;

endpackage

/* hw/rtl/multilevel_priority_queue_top.sv */
// top level of the multilevel priority queue: controller, cell chain, result register
// results are registered; a new item is taken only in IDLE, once the last one is done
// dump: a setup step, then steps that each list one entry or move on to the next level
//   when none is left at the current level, each stretched by output stalls
// the next item is accepted while the last result still waits in the output register
// reset (rst_n, synchronous, active low): store empty, num_levels back to 3, no result pending
module multilevel_priority_queue_top import mpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // command items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command[2:0], item_id[10:3], target_level[13:11], zeros
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], entry_id[9:2], entry_level[12:10], zeros
  output logic        out_tuser,  // entry_valid
  output logic        out_tlast,  // last
  // num_levels register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  state_t state_r, state_nxt;

  // captured command item
  logic [2:0]         cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [LVL_W-1:0]   tl_r;

  logic [NL_W-1:0]    num_levels_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   dump_cnt_r, dump_cnt_nxt;
  logic [LVL_W-1:0]   dump_lv_r, dump_lv_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_id_r, out_id_nxt;
  logic [LVL_W-1:0]   out_lvl_r, out_lvl_nxt;
  logic               out_evalid_r, out_evalid_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctl_t          ctl;
  logic               out_free, load;
  logic               in_acc;
  logic               dump_clr, dump_step;
  status_t            sts;

  // chain wiring between neighboring cells
  logic [CAPACITY:0]  seen_ch;
  logic [CAPACITY:0]  taken_ch;
  logic [LVL_W-1:0]   hit_lvl_ch  [CAPACITY+1];
  logic [ID_BITS-1:0] dump_id_ch  [CAPACITY+1];
  logic [LVL_W-1:0]   dump_lvl_ch [CAPACITY+1];
  logic [CAPACITY-1:0] used_vec;
  logic [ID_BITS-1:0] ident_a [CAPACITY];
  logic [LVL_W-1:0]   level_a [CAPACITY];

  logic               found;
  logic [LVL_W-1:0]   hit_lvl;
  logic               pick_ok;
  logic               dump_last;

  assign seen_ch[0]     = 1'b0;
  assign taken_ch[0]    = 1'b0;
  assign hit_lvl_ch[0]  = '0;
  assign dump_id_ch[0]  = '0;
  assign dump_lvl_ch[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic               prev_used, nxt_used;
      logic [ID_BITS-1:0] nxt_ident;
      logic [LVL_W-1:0]   nxt_level;

      if (gi == 0) begin : g_head
        assign prev_used = 1'b1;
      end else begin : g_mid
        assign prev_used = used_vec[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_end
        assign nxt_used  = 1'b0;
        assign nxt_ident = '0;
        assign nxt_level = '0;
      end else begin : g_inner
        assign nxt_used  = used_vec[gi+1];
        assign nxt_ident = ident_a[gi+1];
        assign nxt_level = level_a[gi+1];
      end

      mpq_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .prev_used    (prev_used),
        .nxt_used     (nxt_used),
        .nxt_ident    (nxt_ident),
        .nxt_level    (nxt_level),
        .seen_in      (seen_ch[gi]),
        .hit_lvl_in   (hit_lvl_ch[gi]),
        .taken_in     (taken_ch[gi]),
        .dump_id_in   (dump_id_ch[gi]),
        .dump_lvl_in  (dump_lvl_ch[gi]),
        .used_o       (used_vec[gi]),
        .ident_o      (ident_a[gi]),
        .level_o      (level_a[gi]),
        .seen_out     (seen_ch[gi+1]),
        .hit_lvl_out  (hit_lvl_ch[gi+1]),
        .taken_out    (taken_ch[gi+1]),
        .dump_id_out  (dump_id_ch[gi+1]),
        .dump_lvl_out (dump_lvl_ch[gi+1])
      );
    end
  endgenerate

  assign found   = seen_ch[CAPACITY];
  assign hit_lvl = hit_lvl_ch[CAPACITY];
  assign pick_ok = taken_ch[CAPACITY];

  assign out_free  = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign dump_last = ((dump_cnt_r + CNT_W'(1)) == cnt_r);

  // status and cell update for the held command
  always_comb begin
    sts           = STS_OK;
    ctl.del       = 1'b0;
    ctl.app       = 1'b0;
    ctl.dump_clr  = dump_clr;
    ctl.dump_step = dump_step;
    ctl.dump_lv   = dump_lv_r;
    ctl.id        = id_r;
    ctl.new_level = tl_r;
    unique case (cmd_r)
      CMD_INSERT: begin
        if ({1'b0, tl_r} >= num_levels_r) begin
          sts = STS_BAD_LEVEL;
        end else if (!found && (cnt_r == CNT_W'(CAPACITY))) begin
          sts = STS_FULL;
        end else begin
          ctl.del = found;
          ctl.app = 1'b1;
        end
      end
      CMD_UP: begin
        ctl.new_level = hit_lvl - LVL_W'(1);
        if (!found) begin
          sts = STS_NOT_FOUND;
        end else if (hit_lvl != '0) begin
          ctl.del = 1'b1;
          ctl.app = 1'b1;
        end
      end
      CMD_DOWN: begin
        ctl.new_level = hit_lvl + LVL_W'(1);
        if (!found) begin
          sts = STS_NOT_FOUND;
        end else if (({1'b0, hit_lvl} + NL_W'(1)) < num_levels_r) begin
          ctl.del = 1'b1;
          ctl.app = 1'b1;
        end
      end
      CMD_REMOVE: begin
        ctl.del = found;
      end
      default: begin
      end
    endcase
    // updates only land in the cycle that issues the result
    if (!(state_r == ST_EXEC && out_free && cmd_r != CMD_DUMP)) begin
      ctl.del = 1'b0;
      ctl.app = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (cmd_r == CMD_DUMP && cnt_r != '0) begin
            state_nxt = ST_DUMP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (out_free && pick_ok && dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready      = 1'b0;
    load           = 1'b0;
    dump_clr       = 1'b0;
    dump_step      = 1'b0;
    dump_lv_nxt    = dump_lv_r;
    dump_cnt_nxt   = dump_cnt_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_lvl_nxt    = out_lvl_r;
    out_evalid_nxt = out_evalid_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EXEC: begin
        if (out_free) begin
          if (cmd_r == CMD_DUMP && cnt_r != '0) begin
            dump_clr     = 1'b1;
            dump_lv_nxt  = '0;
            dump_cnt_nxt = '0;
          end else begin
            load           = 1'b1;
            out_status_nxt = sts;
            out_id_nxt     = '0;
            out_lvl_nxt    = '0;
            out_evalid_nxt = 1'b0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          if (pick_ok) begin
            load           = 1'b1;
            dump_step      = 1'b1;
            out_status_nxt = STS_OK;
            out_id_nxt     = dump_id_ch[CAPACITY];
            out_lvl_nxt    = dump_lvl_ch[CAPACITY];
            out_evalid_nxt = 1'b1;
            out_last_nxt   = dump_last;
            dump_cnt_nxt   = dump_cnt_r + CNT_W'(1);
          end else begin
            // nothing left at this level, go on to the next
            dump_lv_nxt = dump_lv_r + LVL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_nxt       = cnt_r + CNT_W'(ctl.app) - CNT_W'(ctl.del);
  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tdata[2:0];
      id_r  <= in_tdata[10:3];
      tl_r  <= in_tdata[13:11];
    end
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_lvl_r    <= out_lvl_nxt;
    out_evalid_r <= out_evalid_nxt;
    out_last_r   <= out_last_nxt;
    dump_lv_r    <= dump_lv_nxt;
    dump_cnt_r   <= dump_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      num_levels_r <= NL_W'(3);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        // clamp to 1..MAX_LEVELS
        if (cfg_data == '0) begin
          num_levels_r <= NL_W'(1);
        end else if (cfg_data > NL_W'(MAX_LEVELS)) begin
          num_levels_r <= NL_W'(MAX_LEVELS);
        end else begin
          num_levels_r <= cfg_data;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_lvl_r, out_id_r, out_status_r};
  assign out_tuser  = out_evalid_r;
  assign out_tlast  = out_last_r;

  // the fill count always matches the number of occupied cells
  a_cnt_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_vec) == cnt_r)
    else $error("entry count out of step with occupied cells");

  // occupied cells form one run from the head of the chain
  a_used_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (used_vec & (used_vec + CAPACITY'(1))) == '0)
    else $error("hole in the occupied cells");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a dump never lists more entries than are stored
  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |-> dump_cnt_r < cnt_r)
    else $error("dump ran past the stored entries");

  // the entry count does not change while a dump walks the store
  a_dump_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |=> $stable(cnt_r))
    else $error("store changed during dump");

endmodule

/* hw/rtl/mpq_cell.sv */
// one storage slot of the queue chain: match, shift-down and dump pick
module mpq_cell import mpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctl_t          ctl,
  input  logic               prev_used,
  input  logic               nxt_used,
  input  logic [ID_BITS-1:0] nxt_ident,
  input  logic [LVL_W-1:0]   nxt_level,
  input  logic               seen_in,
  input  logic [LVL_W-1:0]   hit_lvl_in,
  input  logic               taken_in,
  input  logic [ID_BITS-1:0] dump_id_in,
  input  logic [LVL_W-1:0]   dump_lvl_in,
  output logic               used_o,
  output logic [ID_BITS-1:0] ident_o,
  output logic [LVL_W-1:0]   level_o,
  output logic               seen_out,
  output logic [LVL_W-1:0]   hit_lvl_out,
  output logic               taken_out,
  output logic [ID_BITS-1:0] dump_id_out,
  output logic [LVL_W-1:0]   dump_lvl_out
);

  logic [ID_BITS-1:0] ident_r, ident_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic               used_r, used_nxt;
  logic               dumped_r, dumped_nxt;
  logic               match, shift, tail, head_free, elig, sel;

  assign match     = used_r && (ident_r == ctl.id);
  assign shift     = ctl.del && (seen_in || match);
  assign tail      = used_r && !nxt_used;
  assign head_free = !used_r && prev_used;

  assign seen_out    = seen_in || match;
  assign hit_lvl_out = match ? level_r : hit_lvl_in;

  // dump pick: first unlisted slot at the current level
  assign elig         = used_r && !dumped_r && (level_r == ctl.dump_lv);
  assign sel          = elig && !taken_in;
  assign taken_out    = taken_in || elig;
  assign dump_id_out  = sel ? ident_r : dump_id_in;
  assign dump_lvl_out = sel ? level_r : dump_lvl_in;

  assign used_o  = used_r;
  assign ident_o = ident_r;
  assign level_o = level_r;

  always_comb begin
    ident_nxt = ident_r;
    level_nxt = level_r;
    used_nxt  = used_r;
    if (shift) begin
      if (tail) begin
        if (ctl.app) begin
          ident_nxt = ctl.id;
          level_nxt = ctl.new_level;
        end else begin
          used_nxt = 1'b0;
        end
      end else begin
        ident_nxt = nxt_ident;
        level_nxt = nxt_level;
      end
    end else if (ctl.app && !ctl.del && head_free) begin
      ident_nxt = ctl.id;
      level_nxt = ctl.new_level;
      used_nxt  = 1'b1;
    end
  end

  always_comb begin
    dumped_nxt = dumped_r;
    if (ctl.dump_clr) begin
      dumped_nxt = 1'b0;
    end else if (ctl.dump_step && sel) begin
      dumped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ident_r <= ident_nxt;
    level_r <= level_nxt;
    if (!rst_n) begin
      used_r   <= 1'b0;
      dumped_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      dumped_r <= dumped_nxt;
    end
  end

endmodule

/* dv/multilevel_priority_queue_checker.sv */
// scoreboard for the multilevel priority queue: watches all channels, predicts and compares
module multilevel_priority_queue_checker import mpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // command[2:0], item_id[10:3], target_level[13:11], zeros
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status[1:0], entry_id[9:2], entry_level[12:10], zeros
  input  logic        out_tuser,  // entry_valid
  input  logic        out_tlast,  // last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    logic [ID_BITS-1:0] entry_id;
    logic [LVL_W-1:0]   entry_level;
    logic               entry_valid;
    logic               last;
  } queue_reply_t;

  // shadow store, slots in arrival order
  logic [ID_BITS-1:0] held_id    [CAPACITY];
  logic [LVL_W-1:0]   held_level [CAPACITY];
  int                 held_count;
  int                 levels_in_use;
  queue_reply_t       due_replies [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input int want, input int got);
    $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_id[i]    = held_id[i + 1];
      held_level[i] = held_level[i + 1];
    end
    held_count--;
  endfunction

  function automatic void add_slot(input logic [ID_BITS-1:0] id, input int lv);
    held_id[held_count]    = id;
    held_level[held_count] = LVL_W'(lv);
    held_count++;
  endfunction

  // update the shadow store for one command and queue the replies it causes
  task automatic apply_command(input logic [2:0] cmd, input logic [ID_BITS-1:0] id,
                               input logic [2:0] tl);
    queue_reply_t r;
    int           pos;
    int           lv;
    int           k;
    r.status      = STS_OK;
    r.entry_id    = '0;
    r.entry_level = '0;
    r.entry_valid = 1'b0;
    r.last        = 1'b1;
    pos = -1;
    if (cmd == CMD_DUMP && held_count != 0) begin
      k = 0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        for (int i = 0; i < held_count; i++) begin
          if (held_level[i] == l) begin
            r.entry_id    = held_id[i];
            r.entry_level = LVL_W'(l);
            r.entry_valid = 1'b1;
            r.last        = (k == held_count - 1);
            due_replies.insert(due_replies.size(), r);
            k++;
          end
        end
      end
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (pos < 0 && held_id[i] == id) pos = i;
      end
      case (cmd)
        CMD_INSERT: begin
          if (tl >= levels_in_use) begin
            r.status = STS_BAD_LEVEL;
          end else if (pos < 0 && held_count >= CAPACITY) begin
            r.status = STS_FULL;
          end else begin
            if (pos >= 0) drop_slot(pos);
            add_slot(id, tl);
          end
        end
        CMD_UP, CMD_DOWN: begin
          if (pos < 0) begin
            r.status = STS_NOT_FOUND;
          end else begin
            lv = held_level[pos];
            if (cmd == CMD_UP && lv > 0) begin
              drop_slot(pos);
              add_slot(id, lv - 1);
            end else if (cmd == CMD_DOWN && lv + 1 < levels_in_use) begin
              drop_slot(pos);
              add_slot(id, lv + 1);
            end
          end
        end
        CMD_REMOVE: begin
          if (pos >= 0) drop_slot(pos);
        end
        default: ;
      endcase
      due_replies.insert(due_replies.size(), r);
    end
  endtask

  always @(posedge clk) begin : watch
    queue_reply_t want;
    int           v;
    if (!rst_n) begin
      held_count    = 0;
      levels_in_use = 3;
      due_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_replies.size() == 0) begin
          report("unexpected reply", 0, out_tdata);
        end else begin
          want = due_replies.pop_front();
          if (out_tdata[1:0] != want.status)
            report("status", want.status, out_tdata[1:0]);
          if (out_tdata[9:2] != want.entry_id)
            report("entry_id", want.entry_id, out_tdata[9:2]);
          if (out_tdata[12:10] != want.entry_level)
            report("entry_level", want.entry_level, out_tdata[12:10]);
          if (out_tuser != want.entry_valid)
            report("entry_valid", want.entry_valid, out_tuser);
          if (out_tlast != want.last)
            report("last", want.last, out_tlast);
        end
      end
      if (cfg_valid && cfg_ready) begin
        v = cfg_data;
        if (v < 1) v = 1;
        if (v > MAX_LEVELS) v = MAX_LEVELS;
        levels_in_use = v;
      end
      if (in_tvalid && in_tready)
        apply_command(in_tdata[2:0], in_tdata[10:3], in_tdata[13:11]);
    end
    pending = due_replies.size();
  end

endmodule

/* dv/multilevel_priority_queue_top_test.sv */
// testbench top for the multilevel priority queue: clock, reset, stimulus and verdict
module multilevel_priority_queue_top_test import mpq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound: worst case is every item a full dump under maximum stalls
  localparam int CYCLE_LIMIT = 400000;
  localparam int ID_POOL     = 40;   // more than the store holds, so inserts can hit full

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // command[2:0], item_id[10:3], target_level[13:11], zeros
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // status[1:0], entry_id[9:2], entry_level[12:10], zeros
  logic        out_tuser;   // entry_valid
  logic        out_tlast;   // last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending;

  // stimulus knobs shared between the driving processes
  int          gap_odds;    // 0 means no idling, else about one gap per gap_odds+1 items
  int          level_cap;   // num_levels as the block applies it
  int          insert_pct;
  logic [7:0]  id_pool [ID_POOL];

  multilevel_priority_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  multilevel_priority_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung block ends the run here
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure, in bursts of stalled cycles
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_tready = 1'b0;
      end else if (gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
        stall      = $urandom_range(1, 6) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // present one command item and hold it until the block takes it;
  // tvalid stays high into the next call so back-to-back items see no bubble
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] id,
                           input logic [2:0] tl);
    if (gap_odds > 0 && $urandom_range(0, gap_odds) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {2'b00, tl, id, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // change num_levels only once every queued reply has drained
  task automatic write_levels(input logic [3:0] value);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    // the block clamps the written value to 1..MAX_LEVELS
    if (value == 0) level_cap = 1;
    else if (value > MAX_LEVELS) level_cap = MAX_LEVELS;
    else level_cap = value;
  endtask

  // one random command: mostly ids from the working pool so that finds succeed
  task automatic issue_random();
    logic [2:0] cmd;
    logic [7:0] id;
    logic [2:0] tl;
    int         r;
    if ($urandom_range(0, 99) < insert_pct) begin
      cmd = CMD_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) cmd = CMD_UP;
      else if (r < 60) cmd = CMD_DOWN;
      else if (r < 85) cmd = CMD_REMOVE;
      else if (r < 97) cmd = CMD_DUMP;
      else cmd = 3'($urandom_range(7, CMD_DUMP + 1));  // undefined command codes
    end
    if ($urandom_range(0, 9) < 8) id = id_pool[$urandom_range(0, ID_POOL - 1)];
    else id = 8'($urandom_range(0, 255));
    // some target levels beyond the ones in use, for the bad level status
    if ($urandom_range(0, 4) == 0) tl = 3'($urandom_range(0, 7));
    else tl = 3'($urandom_range(0, level_cap - 1));
    send_item(cmd, id, tl);
  endtask

  initial begin
    logic [3:0] levels_value;
    logic [7:0] base;
    logic [7:0] step;
    bit         fill;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    gap_odds   = 3;
    level_cap  = 3;
    insert_pct = 45;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed part at the reset setting of three levels
    send_item(CMD_DUMP, 8'h00, 3'd0);        // empty store lists nothing
    send_item(CMD_INSERT, 8'h00, 3'd0);
    send_item(CMD_INSERT, 8'hFF, 3'd2);
    send_item(CMD_INSERT, 8'h55, 3'd7);      // level not in use
    send_item(CMD_INSERT, 8'hAA, 3'd1);
    send_item(CMD_UP, 8'hFF, 3'd7);          // level field ignored here
    send_item(CMD_UP, 8'h00, 3'd0);          // already at the top level
    send_item(CMD_DOWN, 8'hAA, 3'd5);
    send_item(CMD_DOWN, 8'hAA, 3'd0);        // already at the bottom level
    send_item(CMD_UP, 8'h12, 3'd0);          // absent id
    send_item(CMD_DOWN, 8'h12, 3'd0);
    send_item(CMD_REMOVE, 8'h12, 3'd0);      // absent id removes silently
    send_item(CMD_INSERT, 8'hFF, 3'd0);      // reinsert moves the existing entry
    for (int k = 1; k <= 3; k++) send_item(3'(CMD_DUMP + k), 8'h3C, 3'd6);
    send_item(CMD_DUMP, 8'h00, 3'd0);
    send_item(CMD_REMOVE, 8'h00, 3'd0);
    send_item(CMD_DUMP, 8'h00, 3'd0);

    // one level only: the entry at level 2 now sits above the limit
    write_levels(4'd1);
    send_item(CMD_INSERT, 8'h33, 3'd0);
    send_item(CMD_DOWN, 8'hAA, 3'd0);
    send_item(CMD_UP, 8'hAA, 3'd0);
    send_item(CMD_DUMP, 8'h00, 3'd0);

    // random phases, each under its own num_levels setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: levels_value = 4'd8;
        1: levels_value = 4'd0;
        2: levels_value = 4'd15;
        3: levels_value = 4'd1;
        4: levels_value = 4'($urandom_range(2, 7));
        5: levels_value = 4'($urandom_range(9, 14));
        6: levels_value = 4'($urandom_range(0, 15));
        default: levels_value = 4'd3;
      endcase
      write_levels(levels_value);
      // alternate heavy and light idling, none in the closing phase
      if (p == 7) gap_odds = 0;
      else if (p % 2 == 1) gap_odds = 2;
      else gap_odds = 10;
      insert_pct = (p == 3 || p == 5) ? 30 : 50;

      // distinct ids: an odd step walks all 256 values before repeating
      base = 8'($urandom_range(0, 255));
      step = 8'($urandom_range(0, 127) * 2 + 1);
      for (int k = 0; k < ID_POOL; k++) id_pool[k] = 8'(base + k * step);

      // fill phases insert more ids than the store holds before random traffic
      fill = (p == 0 || p == 4 || p == 6);
      if (fill) begin
        for (int k = 0; k < ID_POOL; k++)
          send_item(CMD_INSERT, id_pool[k], 3'($urandom_range(0, level_cap - 1)));
      end
      for (int n = 0; n < (fill ? 20 : 40); n++) issue_random();
    end

    // drain, then leave time for any stray reply to show up
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/multilevel_priority_queue_top.sv
dv/multilevel_priority_queue_checker.sv
dv/multilevel_priority_queue_top_test.sv
